[rtl/core/rsp_pkg.sv]
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared widths, codes and stage records for the rotated spheroid voxel test.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  localparam int COORD_BITS = 12;
  localparam int Z_BITS     = 10;
  localparam int FRAC_BITS  = 8;
  localparam int AXIS_W     = 16;
  localparam int INV_W      = 32;
  localparam int LEVEL_W    = 20;
  localparam int CFG_DATA_W = 32;

  localparam int XY_W  = COORD_BITS + FRAC_BITS;
  localparam int ZC_W  = Z_BITS + FRAC_BITS;
  localparam int D_W   = ((XY_W > ZC_W) ? XY_W : ZC_W) + 1;
  localparam int PR_W  = D_W + AXIS_W;
  localparam int PS_W  = PR_W + 2;
  localparam int L_W   = PS_W - AXIS_W + 2;
  localparam int L2_W  = 2 * L_W;
  localparam int SQ_W  = 2 * D_W;
  localparam int D2_W  = SQ_W + 2;
  localparam int LH_W  = L2_W - INV_W;
  localparam int PH_W  = D2_W - INV_W;
  localparam int QV_W  = L2_W + 2;

  localparam logic [QV_W-1:0] ONE_Q16   = QV_W'(65536);
  localparam logic [QV_W-1:0] BAND_LO   = QV_W'(62260);
  localparam logic [QV_W-1:0] BAND_HI   = QV_W'(68812);
  localparam logic [QV_W-1:0] LEVEL_MAX = QV_W'(20'hFFFFF);

  typedef enum logic [2:0] {
    CFG_CTR_X        = 3'd0,
    CFG_CTR_Y        = 3'd1,
    CFG_CTR_Z        = 3'd2,
    CFG_AXIS_X       = 3'd3,
    CFG_AXIS_Y       = 3'd4,
    CFG_AXIS_Z       = 3'd5,
    CFG_INV_MAJOR_SQ = 3'd6,
    CFG_INV_MINOR_SQ = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    OP_FILL    = 1'b0,
    OP_OUTLINE = 1'b1
  } op_t;

  typedef struct packed {
    logic [XY_W-1:0]          ctr_x;
    logic [XY_W-1:0]          ctr_y;
    logic [ZC_W-1:0]          ctr_z;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [INV_W-1:0]         inv_major_sq;
    logic [INV_W-1:0]         inv_minor_sq;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
  } delta_t;

  typedef struct packed {
    logic            valid;
    op_t             op;
    logic [L2_W-1:0] l2;
    logic [D2_W-1:0] d2;
  } geom_t;

  typedef struct packed {
    logic            valid;
    op_t             op;
    logic [QV_W-1:0] qv;
  } qform_t;

endpackage

`default_nettype wire

[rtl/core/rsp_in_if.sv]
// ----------------------------------------------------------------------------
// rsp_in_if
// Voxel request channel: valid/ready with mode and coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsp_in_if;
  logic                           valid;
  logic                           ready;
  rsp_pkg::op_t                   op;
  logic [rsp_pkg::COORD_BITS-1:0] pixel_x;
  logic [rsp_pkg::COORD_BITS-1:0] pixel_y;
  logic [rsp_pkg::Z_BITS-1:0]     slice_z;

  modport source (output valid, op, pixel_x, pixel_y, slice_z, input ready);
  modport sink   (input valid, op, pixel_x, pixel_y, slice_z, output ready);
endinterface

`default_nettype wire

[rtl/core/rsp_out_if.sv]
// ----------------------------------------------------------------------------
// rsp_out_if
// Test result channel: valid/ready with hit flag and form level.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [rsp_pkg::LEVEL_W-1:0] level;

  modport source (output valid, hit, level, input ready);
  modport sink   (input valid, hit, level, output ready);
endinterface

`default_nettype wire

[rtl/core/rotated_spheroid_pixel_test.sv]
// Throughput: one voxel per cycle while the skid stage is free; seven pipeline
// stages on one enable taken from the skid stage, an output register and a skid stage.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// config registers with their reset values (unit axis along z, unit inverse radii).
// ----------------------------------------------------------------------------
// rotated_spheroid_pixel_test
// Tests voxels against a rotated oblate spheroid, fill or outline band mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_spheroid_pixel_test (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  rsp_pkg::cfg_idx_t                 cfg_idx,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rsp_in_if.sink                            in_ch,
  rsp_out_if.source                         out_ch
);

  rsp_pkg::cfg_t   cfg_r;
  rsp_pkg::delta_t dlt;
  rsp_pkg::geom_t  geo;
  rsp_pkg::qform_t qf;
  logic            en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctr_x        <= '0;
      cfg_r.ctr_y        <= '0;
      cfg_r.ctr_z        <= '0;
      cfg_r.axis_x       <= '0;
      cfg_r.axis_y       <= '0;
      cfg_r.axis_z       <= rsp_pkg::AXIS_W'(32767);
      cfg_r.inv_major_sq <= rsp_pkg::INV_W'(32'h8000_0000);
      cfg_r.inv_minor_sq <= rsp_pkg::INV_W'(32'h8000_0000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rsp_pkg::CFG_CTR_X:        cfg_r.ctr_x <= cfg_wdata[rsp_pkg::XY_W-1:0];
        rsp_pkg::CFG_CTR_Y:        cfg_r.ctr_y <= cfg_wdata[rsp_pkg::XY_W-1:0];
        rsp_pkg::CFG_CTR_Z:        cfg_r.ctr_z <= cfg_wdata[rsp_pkg::ZC_W-1:0];
        rsp_pkg::CFG_AXIS_X:       cfg_r.axis_x <= cfg_wdata[rsp_pkg::AXIS_W-1:0];
        rsp_pkg::CFG_AXIS_Y:       cfg_r.axis_y <= cfg_wdata[rsp_pkg::AXIS_W-1:0];
        rsp_pkg::CFG_AXIS_Z:       cfg_r.axis_z <= cfg_wdata[rsp_pkg::AXIS_W-1:0];
        rsp_pkg::CFG_INV_MAJOR_SQ: cfg_r.inv_major_sq <= cfg_wdata[rsp_pkg::INV_W-1:0];
        rsp_pkg::CFG_INV_MINOR_SQ: cfg_r.inv_minor_sq <= cfg_wdata[rsp_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsp_delta u_delta (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .in_ch (in_ch),
    .dlt   (dlt)
  );

  rsp_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .dlt   (dlt),
    .geo   (geo)
  );

  rsp_form u_form (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .geo   (geo),
    .qf    (qf)
  );

  rsp_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .qf     (qf),
    .en     (en),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/rsp_delta.sv]
// ----------------------------------------------------------------------------
// rsp_delta
// Input stage: takes a voxel transaction and forms the Q.8 offsets from center.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_delta (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  rsp_pkg::cfg_t      cfg,
  rsp_in_if.sink             in_ch,
  output rsp_pkg::delta_t    dlt
);

  logic                           valid_r;
  rsp_pkg::op_t                   op_r;
  logic signed [rsp_pkg::D_W-1:0] dx_r, dy_r, dz_r;
  logic signed [rsp_pkg::D_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [rsp_pkg::D_W-1:0] px_s, py_s, pz_s, cx_s, cy_s, cz_s;

  assign in_ch.ready = en;

  always_comb begin
    px_s   = rsp_pkg::D_W'({in_ch.pixel_x, {rsp_pkg::FRAC_BITS{1'b0}}});
    py_s   = rsp_pkg::D_W'({in_ch.pixel_y, {rsp_pkg::FRAC_BITS{1'b0}}});
    pz_s   = rsp_pkg::D_W'({in_ch.slice_z, {rsp_pkg::FRAC_BITS{1'b0}}});
    cx_s   = rsp_pkg::D_W'(cfg.ctr_x);
    cy_s   = rsp_pkg::D_W'(cfg.ctr_y);
    cz_s   = rsp_pkg::D_W'(cfg.ctr_z);
    dx_nxt = px_s - cx_s;
    dy_nxt = py_s - cy_s;
    dz_nxt = pz_s - cz_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= in_ch.op;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  assign dlt = '{valid: valid_r, op: op_r, dx: dx_r, dy: dy_r, dz: dz_r};

endmodule

`default_nettype wire

[rtl/core/rsp_geom.sv]
// ----------------------------------------------------------------------------
// rsp_geom
// Three stages: axis products and squares, projection rounding and |d|^2,
// then the squared projection l^2.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_geom (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  rsp_pkg::cfg_t    cfg,
  input  rsp_pkg::delta_t  dlt,
  output rsp_pkg::geom_t   geo
);

  localparam int PS_W = rsp_pkg::PS_W;
  localparam int RND_SH = rsp_pkg::AXIS_W - 1;

  // stage 2
  logic                            v2_r;
  rsp_pkg::op_t                    op2_r;
  logic signed [rsp_pkg::PR_W-1:0] prx_r, pry_r, prz_r;
  logic [rsp_pkg::SQ_W-1:0]        sqx_r, sqy_r, sqz_r;
  logic [rsp_pkg::D_W-1:0]         mx, my, mz;

  // stage 3
  logic                     v3_r;
  rsp_pkg::op_t             op3_r;
  logic [rsp_pkg::L_W-1:0]  l8_r;
  logic [rsp_pkg::D2_W-1:0] d2_r;
  logic signed [PS_W-1:0]   psum;
  logic [PS_W-1:0]          pmag;
  logic [PS_W:0]            prnd;

  // stage 4
  logic                     v4_r;
  rsp_pkg::op_t             op4_r;
  logic [rsp_pkg::L2_W-1:0] l2_r;
  logic [rsp_pkg::D2_W-1:0] d2b_r;

  always_comb begin
    mx = (dlt.dx < 0) ? rsp_pkg::D_W'(-dlt.dx) : rsp_pkg::D_W'(dlt.dx);
    my = (dlt.dy < 0) ? rsp_pkg::D_W'(-dlt.dy) : rsp_pkg::D_W'(dlt.dy);
    mz = (dlt.dz < 0) ? rsp_pkg::D_W'(-dlt.dz) : rsp_pkg::D_W'(dlt.dz);
  end

  // projection rounded to Q.8, ties away from zero
  always_comb begin
    psum = PS_W'(prx_r) + PS_W'(pry_r) + PS_W'(prz_r);
    pmag = (psum < 0) ? PS_W'(-psum) : PS_W'(psum);
    prnd = {1'b0, pmag} + ((PS_W + 1)'(1) << (RND_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v2_r <= dlt.valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= dlt.op;
      prx_r <= rsp_pkg::PR_W'(cfg.axis_x) * rsp_pkg::PR_W'(dlt.dx);
      pry_r <= rsp_pkg::PR_W'(cfg.axis_y) * rsp_pkg::PR_W'(dlt.dy);
      prz_r <= rsp_pkg::PR_W'(cfg.axis_z) * rsp_pkg::PR_W'(dlt.dz);
      sqx_r <= rsp_pkg::SQ_W'(mx) * rsp_pkg::SQ_W'(mx);
      sqy_r <= rsp_pkg::SQ_W'(my) * rsp_pkg::SQ_W'(my);
      sqz_r <= rsp_pkg::SQ_W'(mz) * rsp_pkg::SQ_W'(mz);

      op3_r <= op2_r;
      l8_r  <= prnd[PS_W:RND_SH];
      d2_r  <= rsp_pkg::D2_W'(sqx_r) + rsp_pkg::D2_W'(sqy_r) + rsp_pkg::D2_W'(sqz_r);

      op4_r <= op3_r;
      l2_r  <= rsp_pkg::L2_W'(l8_r) * rsp_pkg::L2_W'(l8_r);
      d2b_r <= d2_r;
    end
  end

  assign geo = '{valid: v4_r, op: op4_r, l2: l2_r, d2: d2b_r};

endmodule

`default_nettype wire

[rtl/core/rsp_form.sv]
// ----------------------------------------------------------------------------
// rsp_form
// Three stages: perpendicular part, split Q1.31 products, form value sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_form (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  rsp_pkg::cfg_t    cfg,
  input  rsp_pkg::geom_t   geo,
  output rsp_pkg::qform_t  qf
);

  localparam int INV_W = rsp_pkg::INV_W;
  localparam int PW    = 2 * INV_W;

  // stage 5
  logic                     v5_r;
  rsp_pkg::op_t             op5_r;
  logic [rsp_pkg::D2_W-1:0] perp_r;
  logic [rsp_pkg::L2_W-1:0] l2_r;
  logic [rsp_pkg::D2_W-1:0] perp_nxt;

  // stage 6: low and high halves times the inverse
  logic                             v6_r;
  rsp_pkg::op_t                     op6_r;
  logic [PW-1:0]                    pml_r, lml_r;
  logic [rsp_pkg::PH_W+INV_W-1:0]   pmh_r;
  logic [rsp_pkg::LH_W+INV_W-1:0]   lmh_r;

  // stage 7
  logic                     v7_r;
  rsp_pkg::op_t             op7_r;
  logic [rsp_pkg::QV_W-1:0] qv_r;
  logic [rsp_pkg::QV_W-1:0] qv_nxt;

  // clamp at zero when the axis is not of unit length
  always_comb begin
    if (rsp_pkg::L2_W'(geo.d2) > geo.l2) begin
      perp_nxt = geo.d2 - rsp_pkg::D2_W'(geo.l2);
    end else begin
      perp_nxt = '0;
    end
  end

  // (hi * inv) << 1 plus (lo * inv) >> 31 is exactly (a * inv) >> 31
  always_comb begin
    qv_nxt = rsp_pkg::QV_W'({pmh_r, 1'b0}) + rsp_pkg::QV_W'(pml_r[PW-1:INV_W-1])
           + rsp_pkg::QV_W'({lmh_r, 1'b0}) + rsp_pkg::QV_W'(lml_r[PW-1:INV_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= geo.valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op5_r  <= geo.op;
      perp_r <= perp_nxt;
      l2_r   <= geo.l2;

      op6_r <= op5_r;
      pml_r <= PW'(perp_r[INV_W-1:0]) * PW'(cfg.inv_major_sq);
      pmh_r <= (rsp_pkg::PH_W + INV_W)'(perp_r[rsp_pkg::D2_W-1:INV_W])
             * (rsp_pkg::PH_W + INV_W)'(cfg.inv_major_sq);
      lml_r <= PW'(l2_r[INV_W-1:0]) * PW'(cfg.inv_minor_sq);
      lmh_r <= (rsp_pkg::LH_W + INV_W)'(l2_r[rsp_pkg::L2_W-1:INV_W])
             * (rsp_pkg::LH_W + INV_W)'(cfg.inv_minor_sq);

      op7_r <= op6_r;
      qv_r  <= qv_nxt;
    end
  end

  assign qf = '{valid: v7_r, op: op7_r, qv: qv_r};

endmodule

`default_nettype wire

[rtl/core/rsp_out.sv]
// ----------------------------------------------------------------------------
// rsp_out
// Hit decision and level saturation into an output register with skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_out (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  rsp_pkg::qform_t  qf,
  output logic             en,
  rsp_out_if.source        out_ch
);

  logic                        out_valid_r, skid_valid_r;
  logic                        out_hit_r, skid_hit_r;
  logic [rsp_pkg::LEVEL_W-1:0] out_level_r, skid_level_r;
  logic                        hit_c;
  logic [rsp_pkg::LEVEL_W-1:0] level_c;
  logic                        take;
  logic                        stalled;

  always_comb begin
    if (qf.op == rsp_pkg::OP_FILL) begin
      hit_c = (qf.qv <= rsp_pkg::ONE_Q16);
    end else begin
      hit_c = (qf.qv >= rsp_pkg::BAND_LO) && (qf.qv <= rsp_pkg::BAND_HI);
    end
    if (qf.qv > rsp_pkg::LEVEL_MAX) begin
      level_c = rsp_pkg::LEVEL_MAX[rsp_pkg::LEVEL_W-1:0];
    end else begin
      level_c = qf.qv[rsp_pkg::LEVEL_W-1:0];
    end
  end

  // the pipeline moves only while the skid stage is free
  assign en      = !skid_valid_r;
  assign take    = qf.valid && en;
  assign stalled = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (stalled) begin
      if (take) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (stalled) begin
      if (take) begin
        skid_hit_r   <= hit_c;
        skid_level_r <= level_c;
      end
    end else if (skid_valid_r) begin
      out_hit_r   <= skid_hit_r;
      out_level_r <= skid_level_r;
    end else if (take) begin
      out_hit_r   <= hit_c;
      out_level_r <= level_c;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;
  assign out_ch.level = out_level_r;

endmodule

`default_nettype wire

[rtl/core/rsp_chk.sv]
// ----------------------------------------------------------------------------
// rsp_chk
// Port-level checks for the spheroid voxel test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_hit,
  input wire logic [rsp_pkg::LEVEL_W-1:0] out_level
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input side blocks only when a result is waiting
  a_block_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no result pending");

  // a hit never sits above the outline band
  a_hit_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (rsp_pkg::QV_W'(out_level) <= rsp_pkg::BAND_HI))
    else $error("hit with level beyond outline band");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_level))
    else $error("result payload changed while stalled");

endmodule

bind rotated_spheroid_pixel_test rsp_chk u_rsp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_level (out_ch.level)
);

`default_nettype wire
